/* rtl/assert_macros.svh */
// Assertion macros used by the port-level checker.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

/* rtl/afc_pkg.sv */
// Package for the frustum cull block: widths, register indexes, pipeline types.
// No dependencies; compile first.
`timescale 1ns / 1ps
`default_nettype none

package afc_pkg;

	localparam int FIELD_W     = 16;          // width of every request field
	localparam int COORD_VW    = FIELD_W + 1; // coordinate after extension
	localparam int SUM_W       = COORD_VW + 1;
	localparam int HALF_W      = 2 * COORD_VW;
	localparam int NUM_PLANES  = 6;
	localparam int NUM_AXES    = 3;
	localparam int PLANE_W     = 64;
	localparam int PART_W      = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int PIPE_DEPTH  = 5;
	localparam int COORD_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF   = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		PL_LEFT   = 3'd0,
		PL_RIGHT  = 3'd1,
		PL_BOTTOM = 3'd2,
		PL_TOP    = 3'd3,
		PL_NEAR   = 3'd4,
		PL_FAR    = 3'd5
	} plane_idx_t;

	typedef logic [PLANE_W-1:0] plane_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} pipe_en_t;

	// Vertex width: centre scaled up by the fraction plus half-extent, one guard bit.
	function automatic int vert_w(input int frac);
		int a;
		a = SUM_W + frac;
		return ((a > HALF_W) ? a : HALF_W) + 1;
	endfunction

endpackage

`default_nettype wire

/* rtl/afc_if.sv */
// Request and response channel interfaces of the frustum cull block.
// Depends on afc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface afc_req_if
	import afc_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] object_pos_x;
	logic [FIELD_W-1:0] object_pos_y;
	logic [FIELD_W-1:0] object_pos_z;
	logic [FIELD_W-1:0] collider_off_x;
	logic [FIELD_W-1:0] collider_off_y;
	logic [FIELD_W-1:0] collider_off_z;
	logic [FIELD_W-1:0] object_scale_x;
	logic [FIELD_W-1:0] object_scale_y;
	logic [FIELD_W-1:0] object_scale_z;
	logic [FIELD_W-1:0] collider_scale_x;
	logic [FIELD_W-1:0] collider_scale_y;
	logic [FIELD_W-1:0] collider_scale_z;

	modport source (
		output valid, object_pos_x, object_pos_y, object_pos_z,
		output collider_off_x, collider_off_y, collider_off_z,
		output object_scale_x, object_scale_y, object_scale_z,
		output collider_scale_x, collider_scale_y, collider_scale_z,
		input  ready
	);
	modport sink (
		input  valid, object_pos_x, object_pos_y, object_pos_z,
		input  collider_off_x, collider_off_y, collider_off_z,
		input  object_scale_x, object_scale_y, object_scale_z,
		input  collider_scale_x, collider_scale_y, collider_scale_z,
		output ready
	);
endinterface

interface afc_rsp_if;
	logic valid;
	logic ready;
	logic visible;

	modport source (output valid, visible, input ready);
	modport sink (input valid, visible, output ready);
endinterface

`default_nettype wire

/* rtl/afc_box.sv */
// Box builder: extends the request fields, forms centre and half-extent,
// then the minimum and maximum vertex per axis (stages 1 and 2). Uses afc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module afc_box
	import afc_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire pipe_en_t                        en,
	input  wire logic [FIELD_W-1:0]              pos    [NUM_AXES],
	input  wire logic [FIELD_W-1:0]              off    [NUM_AXES],
	input  wire logic [FIELD_W-1:0]              oscale [NUM_AXES],
	input  wire logic [FIELD_W-1:0]              cscale [NUM_AXES],
	output logic signed [vert_w(FRAC_BITS)-1:0]  vmax_s2 [NUM_AXES],
	output logic signed [vert_w(FRAC_BITS)-1:0]  vmin_s2 [NUM_AXES]
);

	localparam int VERT_W  = vert_w(FRAC_BITS);
	localparam int SIGN_IX = (COORD_WIDTH <= FIELD_W) ? COORD_WIDTH - 1 : FIELD_W - 1;

	typedef logic signed [COORD_VW-1:0] coord_t;
	typedef logic signed [VERT_W-1:0]   vert_t;

	logic signed [SUM_W-1:0]  sum_s1  [NUM_AXES];
	logic signed [HALF_W-1:0] half_s1 [NUM_AXES];

	// Take the low COORD_WIDTH bits as two's complement; wider formats read unsigned.
	function automatic coord_t coord_in(input logic [FIELD_W-1:0] f);
		coord_t c;
		for (int i = 0; i < COORD_VW; i++) begin
			if (i < COORD_WIDTH && i < FIELD_W) begin
				c[i] = f[i];
			end else if (COORD_WIDTH <= FIELD_W) begin
				c[i] = f[SIGN_IX];
			end else begin
				c[i] = 1'b0;
			end
		end
		return c;
	endfunction

	always_ff @(posedge clk) begin
		for (int a = 0; a < NUM_AXES; a++) begin
			if (en.s1) begin
				sum_s1[a]  <= SUM_W'(coord_in(pos[a])) + SUM_W'(coord_in(off[a]));
				half_s1[a] <= coord_in(oscale[a]) * coord_in(cscale[a]);
			end
			if (en.s2) begin
				vmax_s2[a] <= (vert_t'(sum_s1[a]) <<< FRAC_BITS) + vert_t'(half_s1[a]);
				vmin_s2[a] <= (vert_t'(sum_s1[a]) <<< FRAC_BITS) - vert_t'(half_s1[a]);
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/afc_plane.sv */
// Plane tester: positive-vertex products (stage 3), partial sums (stage 4),
// final sum and sign for all six planes (stage 5). Uses afc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module afc_plane
	import afc_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire pipe_en_t                        en,
	input  wire plane_t                          planes  [NUM_PLANES],
	input  wire logic signed [vert_w(FRAC_BITS)-1:0] vmax_s2 [NUM_AXES],
	input  wire logic signed [vert_w(FRAC_BITS)-1:0] vmin_s2 [NUM_AXES],
	output logic                                 visible_s5
);

	localparam int VERT_W = vert_w(FRAC_BITS);
	localparam int PROD_W = VERT_W + PART_W;

	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [PROD_W:0]   psum_t;
	typedef logic signed [PROD_W+1:0] acc_t;

	prod_t prod_s3 [NUM_PLANES][NUM_AXES];
	psum_t pa_s4   [NUM_PLANES];
	psum_t pb_s4   [NUM_PLANES];
	logic  [NUM_PLANES-1:0] reject;

	function automatic logic signed [PART_W-1:0] part(input plane_t pl, input int k);
		return pl[k*PART_W +: PART_W];
	endfunction

	always_comb begin
		acc_t acc;
		for (int p = 0; p < NUM_PLANES; p++) begin
			acc = acc_t'(pa_s4[p]) + acc_t'(pb_s4[p]);
			reject[p] = acc[PROD_W+1];
		end
	end

	always_ff @(posedge clk) begin
		for (int p = 0; p < NUM_PLANES; p++) begin
			if (en.s3) begin
				for (int a = 0; a < NUM_AXES; a++) begin
					// Non-negative normal component picks the max vertex on that axis.
					prod_s3[p][a] <= part(planes[p], a) *
						(part(planes[p], a) >= 0 ? vmax_s2[a] : vmin_s2[a]);
				end
			end
			if (en.s4) begin
				pa_s4[p] <= psum_t'(prod_s3[p][0]) + psum_t'(prod_s3[p][1]);
				pb_s4[p] <= psum_t'(prod_s3[p][2]) +
					(psum_t'(part(planes[p], NUM_AXES)) <<< FRAC_BITS);
			end
		end
		if (en.s5) begin
			visible_s5 <= ~|reject;
		end
	end

endmodule

`default_nettype wire

/* rtl/aabb_frustum_cull.sv */
// Top level of the bounding-box frustum cull: plane registers, valid chain,
// box builder and plane tester. Depends on afc_pkg, afc_if, afc_box, afc_plane.
//
//   Channel   Direction  Handshake               Contents
//   req       in         req.valid / req.ready   position, offset, two scales per axis
//   rsp       out        rsp.valid / rsp.ready   visible flag
//   cfg       in         cfg_we                  plane index and 64-bit coefficients
//
// One box enters per cycle while req.ready is high; back-pressure on rsp can hold it off.
// Its verdict passes through five register stages (extend and multiply scales, vertices,
// plane products, partial sums, final sum and sign) before it shows on rsp.
// Reset clears all six planes, so every box reads visible until planes are written.
// A stall on rsp holds the output register; each stage takes new data whenever it
// is empty or the stage after it moves, so bubbles close up and nothing repeats.
`timescale 1ns / 1ps
`default_nettype none

module aabb_frustum_cull
	import afc_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	afc_req_if.sink                   req,
	afc_rsp_if.source                 rsp,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [PLANE_W-1:0]   cfg_wdata
);

	localparam int VERT_W = vert_w(FRAC_BITS);

	plane_t   planes_q [NUM_PLANES];
	logic     v_s1, v_s2, v_s3, v_s4, v_s5;
	pipe_en_t en;
	logic     visible_s5;

	logic [FIELD_W-1:0]       pos    [NUM_AXES];
	logic [FIELD_W-1:0]       off    [NUM_AXES];
	logic [FIELD_W-1:0]       oscale [NUM_AXES];
	logic [FIELD_W-1:0]       cscale [NUM_AXES];
	logic signed [VERT_W-1:0] vmax_s2 [NUM_AXES];
	logic signed [VERT_W-1:0] vmin_s2 [NUM_AXES];

	// Plane registers: write on enable, drop writes to indexes past the far plane.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NUM_PLANES; p++) begin
				planes_q[p] <= '0;
			end
		end else if (cfg_we) begin
			case (plane_idx_t'(cfg_idx))
				PL_LEFT:   planes_q[PL_LEFT]   <= cfg_wdata;
				PL_RIGHT:  planes_q[PL_RIGHT]  <= cfg_wdata;
				PL_BOTTOM: planes_q[PL_BOTTOM] <= cfg_wdata;
				PL_TOP:    planes_q[PL_TOP]    <= cfg_wdata;
				PL_NEAR:   planes_q[PL_NEAR]   <= cfg_wdata;
				PL_FAR:    planes_q[PL_FAR]    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Load enables: a stage advances when empty or when the stage after it advances.
	always_comb begin
		en.s5 = !v_s5 || rsp.ready;
		en.s4 = !v_s4 || en.s5;
		en.s3 = !v_s3 || en.s4;
		en.s2 = !v_s2 || en.s3;
		en.s1 = !v_s1 || en.s2;
	end

	assign req.ready   = en.s1;
	assign rsp.valid   = v_s5;
	assign rsp.visible = visible_s5;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= req.valid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
			if (en.s5) v_s5 <= v_s4;
		end
	end

	// Gather the request fields per axis.
	always_comb begin
		pos[0]    = req.object_pos_x;
		pos[1]    = req.object_pos_y;
		pos[2]    = req.object_pos_z;
		off[0]    = req.collider_off_x;
		off[1]    = req.collider_off_y;
		off[2]    = req.collider_off_z;
		oscale[0] = req.object_scale_x;
		oscale[1] = req.object_scale_y;
		oscale[2] = req.object_scale_z;
		cscale[0] = req.collider_scale_x;
		cscale[1] = req.collider_scale_y;
		cscale[2] = req.collider_scale_z;
	end

	afc_box #(
		.COORD_WIDTH (COORD_WIDTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_box (
		.clk     (clk),
		.en      (en),
		.pos     (pos),
		.off     (off),
		.oscale  (oscale),
		.cscale  (cscale),
		.vmax_s2 (vmax_s2),
		.vmin_s2 (vmin_s2)
	);

	afc_plane #(
		.FRAC_BITS (FRAC_BITS)
	) u_plane (
		.clk        (clk),
		.en         (en),
		.planes     (planes_q),
		.vmax_s2    (vmax_s2),
		.vmin_s2    (vmin_s2),
		.visible_s5 (visible_s5)
	);

endmodule

`default_nettype wire

/* rtl/afc_checker.sv */
// Port-level checker for the frustum cull block, bound to the top level.
// Depends on afc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module afc_checker
	import afc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire logic rsp_visible
);

	localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

	logic [CNT_W-1:0] pend_q;
	logic             req_acc, rsp_acc;

	assign req_acc = req_valid && req_ready;
	assign rsp_acc = rsp_valid && rsp_ready;

	// Track requests in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (req_acc && !rsp_acc) begin
			pend_q <= pend_q + CNT_W'(1);
		end else if (rsp_acc && !req_acc) begin
			pend_q <= pend_q - CNT_W'(1);
		end
	end

	`ASSERT_IMPLY(a_no_invented_rsp, clk, arst_n, rsp_valid, pend_q != '0)
	`ASSERT_IMPLY(a_depth_bound, clk, arst_n, 1'b1, pend_q <= CNT_W'(PIPE_DEPTH))
	`ASSERT_IMPLY(a_ready_when_empty, clk, arst_n, pend_q == '0, req_ready)
	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_visible))

endmodule

bind aabb_frustum_cull afc_checker u_afc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_visible (rsp.visible)
);

`default_nettype wire

/* sim/cull_verdict_pkg.sv */
// Scoreboard for the frustum cull bench: box request type and the visibility predictor.
// Depends on afc_pkg for widths and the plane word layout.
`timescale 1ns / 1ps

package cull_verdict_pkg;
	import afc_pkg::*;

	typedef struct packed {
		logic [NUM_AXES-1:0][FIELD_W-1:0] pos;
		logic [NUM_AXES-1:0][FIELD_W-1:0] off;
		logic [NUM_AXES-1:0][FIELD_W-1:0] obj_scale;
		logic [NUM_AXES-1:0][FIELD_W-1:0] col_scale;
	} cull_box_t;

	class cull_verdicts;
		plane_t planes [NUM_PLANES];
		bit     pending_visible [$];
		int     mismatches;

		function new();
			foreach (planes[i]) planes[i] = '0;
			mismatches = 0;
		endfunction

		// writes to the spare indexes are dropped, as in the block
		function void set_plane(int idx, plane_t value);
			if (idx < NUM_PLANES) planes[idx] = value;
		endfunction

		function bit predict_visible(cull_box_t b);
			longint one;
			longint centre [NUM_AXES];
			longint half [NUM_AXES];
			longint acc;
			longint n;
			longint vert;
			bit     vis;
			one = longint'(1) << FRAC_BITS_DEF;
			vis = 1'b1;
			for (int a = 0; a < NUM_AXES; a++) begin
				centre[a] = (longint'($signed(b.pos[a])) + longint'($signed(b.off[a]))) * one;
				half[a]   = longint'($signed(b.obj_scale[a])) * longint'($signed(b.col_scale[a]));
			end
			for (int p = 0; p < NUM_PLANES; p++) begin
				acc = longint'($signed(planes[p][PLANE_W-1 -: PART_W])) * one;
				for (int a = 0; a < NUM_AXES; a++) begin
					n    = longint'($signed(planes[p][a*PART_W +: PART_W]));
					vert = (n >= 0) ? centre[a] + half[a] : centre[a] - half[a];
					acc += n * vert;
				end
				if (acc < 0) vis = 1'b0;
			end
			return vis;
		endfunction

		function void note_box(cull_box_t b);
			pending_visible.push_back(predict_visible(b));
		endfunction

		function void check_verdict(logic visible);
			bit want;
			if (pending_visible.size() == 0) begin
				$error("visible: response with no request waiting, actual %0b", visible);
				mismatches++;
			end else begin
				want = pending_visible.pop_front();
				if (visible !== want) begin
					$error("visible mismatch: expected %0b, actual %0b", want, visible);
					mismatches++;
				end
			end
		endfunction

		function int pending();
			return pending_visible.size();
		endfunction
	endclass

endpackage

/* sim/tb_top.sv */
// Bench top for aabb_frustum_cull: drives box requests and plane writes, checks verdicts.
// Depends on afc_pkg, afc_if, cull_verdict_pkg and the block itself.
`timescale 1ns / 1ps

module tb_top;
	import afc_pkg::*;
	import cull_verdict_pkg::*;

	localparam int IDLE_PCT    = 38;
	localparam int HOLD_CYCLES = 150;
	localparam int CYCLE_LIMIT = 200000;
	localparam int WILD_PCT    = 30;

	// the two indexes past the far plane: the block must ignore writes there
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

	typedef enum {
		PS_ZERO,     // reset value: nothing is ever culled
		PS_BOX16,    // unit normals, a cube of half-width 16.0 about the origin
		PS_FRUSTUM,  // scaled, slightly tilted normals with random offsets
		PS_RANDOM,   // every coefficient bit random
		PS_EXTREME,  // fixed mix of the most negative and most positive parts
		PS_CORNER,   // each part drawn from min, max, zero and minus one
		PS_ALL_ONES  // every part minus one
	} plane_set_e;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	plane_t cfg_wdata;

	afc_req_if req_ch ();
	afc_rsp_if rsp_ch ();

	aabb_frustum_cull i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	cull_verdicts verdicts;

	bit req_steady;   // sender offers back to back while set
	bit rsp_steady;   // receiver never idles while set
	int holds_asked;  // bumped by the stimulus to ask for one long hold-off
	int holds_served;
	int hold_left;
	int cycle_count;

	always #4 clk = ~clk;

	// Receiver: random back-pressure, with a long hold-off on request. The hold is
	// counted here so that the sender keeps offering and the pipeline backs up.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else if (holds_asked != holds_served) begin
			holds_served++;
			hold_left = HOLD_CYCLES;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= rsp_steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Check every verdict the receiver takes against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) verdicts.check_verdict(rsp_ch.visible);
	end

	// Hard stop: should never fire on a healthy run.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("status: fail");
		$finish;
	end

	// Offer one box and hold it until the block takes it; random idle cycles go
	// in front unless the sender is running back to back. The prediction is noted
	// at the accepting edge so the drain check below never misses a request.
	task automatic offer_box(input cull_box_t b);
		while (!req_steady && $urandom_range(99) < IDLE_PCT) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid            <= 1'b1;
		req_ch.object_pos_x     <= b.pos[0];
		req_ch.object_pos_y     <= b.pos[1];
		req_ch.object_pos_z     <= b.pos[2];
		req_ch.collider_off_x   <= b.off[0];
		req_ch.collider_off_y   <= b.off[1];
		req_ch.collider_off_z   <= b.off[2];
		req_ch.object_scale_x   <= b.obj_scale[0];
		req_ch.object_scale_y   <= b.obj_scale[1];
		req_ch.object_scale_z   <= b.obj_scale[2];
		req_ch.collider_scale_x <= b.col_scale[0];
		req_ch.collider_scale_y <= b.col_scale[1];
		req_ch.collider_scale_z <= b.col_scale[2];
		do @(posedge clk); while (!req_ch.ready);
		verdicts.note_box(b);
	endtask

	// Drop valid and wait for every outstanding verdict; one result per request,
	// so the block is empty once the last one is through.
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (verdicts.pending() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input plane_t data);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		verdicts.set_plane(idx, data);
	endtask

	function automatic plane_t make_plane(int p, plane_set_e mode);
		int     part [4];
		int     axis;
		int     dir;
		int     s;
		plane_t v;
		axis = p / 2;
		dir  = (p % 2 == 0) ? 1 : -1;
		foreach (part[k]) part[k] = 0;
		case (mode)
			PS_ZERO:     return '0;
			PS_ALL_ONES: return '1;
			PS_RANDOM:   return {$urandom, $urandom};
			PS_BOX16: begin
				part[axis] = dir;
				part[3]    = 4096;
			end
			PS_FRUSTUM: begin
				s = $urandom_range(1, 8);
				for (int a = 0; a < NUM_AXES; a++) part[a] = int'($urandom_range(0, 2)) - 1;
				part[axis] = dir * s;
				part[3]    = s * int'($urandom_range(256, 4095));
			end
			PS_EXTREME: begin
				for (int a = 0; a < NUM_AXES; a++) part[a] = ((p + a) % 2 == 0) ? 32767 : -32768;
				part[3] = (p % 2 == 0) ? -32768 : 32767;
			end
			PS_CORNER: begin
				foreach (part[k]) begin
					case ($urandom_range(3))
						0: part[k] = -32768;
						1: part[k] = 32767;
						2: part[k] = 0;
						default: part[k] = -1;
					endcase
				end
			end
			default: return '0;
		endcase
		for (int k = 0; k < 4; k++) v[k*PART_W +: PART_W] = part[k][PART_W-1:0];
		return v;
	endfunction

	// Registers change only with the block empty: drain, then write all six.
	task automatic load_planes(input plane_set_e mode);
		wait_drained();
		for (int p = 0; p < NUM_PLANES; p++) write_reg(CFG_IDX_W'(p), make_plane(p, mode));
		cfg_we <= 1'b0;
	endtask

	function automatic cull_box_t uniform_box(int pos, int off, int os, int cs);
		cull_box_t b;
		for (int a = 0; a < NUM_AXES; a++) begin
			b.pos[a]       = pos[FIELD_W-1:0];
			b.off[a]       = off[FIELD_W-1:0];
			b.obj_scale[a] = os[FIELD_W-1:0];
			b.col_scale[a] = cs[FIELD_W-1:0];
		end
		return b;
	endfunction

	// Most boxes sit around the planes so verdicts go both ways; the rest are
	// raw 16-bit noise to reach the field extremes and every bit.
	function automatic cull_box_t rand_box();
		cull_box_t b;
		if ($urandom_range(99) < WILD_PCT) begin
			b = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		end else begin
			for (int a = 0; a < NUM_AXES; a++) begin
				b.pos[a]       = FIELD_W'(int'($urandom_range(0, 12288)) - 6144);
				b.off[a]       = FIELD_W'(int'($urandom_range(0, 2048)) - 1024);
				b.obj_scale[a] = FIELD_W'(int'($urandom_range(0, 768)) - 128);
				b.col_scale[a] = FIELD_W'(int'($urandom_range(0, 640)) - 64);
			end
		end
		return b;
	endfunction

	// A run of random boxes; hold_at picks the request after which the receiver
	// is asked for its long hold-off (negative for none).
	task automatic run_random(input int count, input int hold_at);
		for (int i = 0; i < count; i++) begin
			if (i == hold_at) holds_asked++;
			offer_box(rand_box());
		end
	endtask

	initial begin
		verdicts     = new();
		clk          = 1'b0;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_idx      = '0;
		cfg_wdata    = '0;
		req_steady   = 1'b0;
		rsp_steady   = 1'b0;
		holds_asked  = 0;
		holds_served = 0;
		hold_left    = 0;
		rsp_ch.ready = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.object_pos_x     = '0;
		req_ch.object_pos_y     = '0;
		req_ch.object_pos_z     = '0;
		req_ch.collider_off_x   = '0;
		req_ch.collider_off_y   = '0;
		req_ch.collider_off_z   = '0;
		req_ch.object_scale_x   = '0;
		req_ch.object_scale_y   = '0;
		req_ch.object_scale_z   = '0;
		req_ch.collider_scale_x = '0;
		req_ch.collider_scale_y = '0;
		req_ch.collider_scale_z = '0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Planes at reset are all zero: every box, however extreme, is visible.
		offer_box(uniform_box(0, 0, 0, 0));
		offer_box(uniform_box(32767, 32767, 32767, 32767));
		offer_box(uniform_box(-32768, -32768, -32768, -32768));
		offer_box(uniform_box(-1, -1, -1, -1));

		// Writes to the spare indexes must leave the planes untouched.
		wait_drained();
		write_reg(IDX_SPARE_LO, '1);
		write_reg(IDX_SPARE_HI, '1);
		cfg_we <= 1'b0;
		offer_box(uniform_box(4096, 4096, 256, 256));

		// Cube of half-width 16.0: inside, far outside, touching, just outside,
		// a negative half-extent that swaps the vertices, and the largest products.
		load_planes(PS_BOX16);
		offer_box(uniform_box(0, 0, 256, 256));
		offer_box(uniform_box(32767, 32767, 256, 256));
		offer_box(uniform_box(6144, 0, 256, 2048));
		offer_box(uniform_box(6144, 0, 256, 2047));
		offer_box(uniform_box(6144, 0, -256, 2048));
		offer_box(uniform_box(-32768, -32768, -32768, -32768));
		offer_box(uniform_box(0, 0, -32768, 32767));
		offer_box(uniform_box(0, 0, 32767, 32767));

		// Zero normal with a negative distance rejects every box.
		wait_drained();
		write_reg(PL_FAR, {{PART_W{1'b1}}, {(3*PART_W){1'b0}}});
		cfg_we <= 1'b0;
		offer_box(uniform_box(0, 0, 256, 256));

		// Extreme coefficients against extreme boxes.
		load_planes(PS_EXTREME);
		offer_box(uniform_box(32767, 32767, 32767, 32767));
		offer_box(uniform_box(-32768, -32768, -32768, -32768));
		offer_box(uniform_box(0, 0, 0, 0));
		offer_box(uniform_box(-1, -1, -1, -1));

		// Random part: mostly plausible frusta, then noise and corner planes.
		load_planes(PS_FRUSTUM);
		run_random(250, -1);

		// A long stretch with neither side idling.
		load_planes(PS_FRUSTUM);
		req_steady = 1'b1;
		rsp_steady = 1'b1;
		run_random(250, -1);
		rsp_steady = 1'b0;

		// Receiver holds off while the sender keeps pushing, so the pipe fills.
		load_planes(PS_FRUSTUM);
		run_random(200, 20);
		req_steady = 1'b0;

		load_planes(PS_RANDOM);
		run_random(200, -1);
		load_planes(PS_CORNER);
		run_random(150, -1);
		load_planes(PS_ALL_ONES);
		run_random(100, -1);
		load_planes(PS_ZERO);
		run_random(200, -1);

		// Let any stray response show up before deciding.
		wait_drained();
		repeat (4 * PIPE_DEPTH) @(posedge clk);
		if (verdicts.mismatches == 0 && verdicts.pending() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
